// File: hw/rtl/endstop_qualifier_homing_sequencer_defines.svh
// assertion helpers used by the sequencer rtl
`ifndef ENDSTOP_QUALIFIER_HOMING_SEQUENCER_DEFINES_SVH
`define ENDSTOP_QUALIFIER_HOMING_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EQHS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("eqhs same-cycle check failed");

// next-cycle implication, checked outside reset
`define EQHS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("eqhs next-cycle check failed");

`endif

// File: hw/rtl/eqhs_pkg.sv
package eqhs_pkg;

    // default sizes
    localparam int NUM_SWITCHES_DEF = 6;
    localparam int TIME_WIDTH_DEF   = 32;

    // axes and field widths
    localparam int AXES        = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int PHASE_W     = 3;
    localparam int PERIOD_W    = 16;

    // opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESUME_HOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_DELAY  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_INVERT  = 3'd5;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST    = 32'd10000;
    localparam logic [CFG_DATA_W-1:0] RESUME_HOLD_RST = 32'd1000000;
    localparam logic [PERIOD_W-1:0]   PULSE_WIDTH_RST = 16'd5;
    localparam logic [PERIOD_W-1:0]   FAST_DELAY_RST  = 16'd500;
    localparam logic [PERIOD_W-1:0]   SLOW_DELAY_RST  = 16'd2000;
    localparam logic [AXES-1:0]       DIR_INVERT_RST  = 3'd0;

    // homing phase codes
    localparam logic [PHASE_W-1:0] PHASE_IDLE         = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_AWAY_FIRST   = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_TOWARDS_FAST = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_AWAY_SECOND  = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_SLOW         = 3'd4;

    // period count value that forces a sample on the next tick
    localparam logic [PERIOD_W-1:0] SAMPLE_NOW = 16'hFFFF;

endpackage

// File: hw/rtl/endstop_qualifier_homing_sequencer.sv
// Limit switch debounce and axis homing sequencer. Each item is either a time tick carrying
// the raw active-low switch and resume levels, or a start-homing command with an axis mask.
// Every item gives exactly one result: debounced switch flags, resume status, step pulses,
// direction levels and homing status. The block takes one item per clock cycle and the
// result appears in the output register on the cycle after acceptance; s_ready only drops
// while that register holds a result that m_ready has not taken. The cycle's path is the
// saturating switch timers and their compare against debounce_ticks, followed by the homing
// step logic (one 16-bit compare, one increment, one compare against the pulse width).
// Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data and takes effect
// on the next item; indexes beyond the register list are ignored.
`include "endstop_qualifier_homing_sequencer_defines.svh"

module endstop_qualifier_homing_sequencer
    import eqhs_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF,
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,

    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic [AXES-1:0]         s_axis_mask,
    input  logic [NUM_SWITCHES-1:0] s_switch_levels,
    input  logic                    s_resume_level,

    // result items
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [NUM_SWITCHES-1:0] m_switches_pressed,
    output logic                    m_resume_ok,
    output logic [AXES-1:0]         m_step_pulses,
    output logic [AXES-1:0]         m_dir_levels,
    output logic                    m_homing_busy,
    output logic [PHASE_W-1:0]      m_homing_phase,
    output logic                    m_homing_done
);

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    // configuration registers
    logic [CFG_DATA_W-1:0] debounce_ticks_reg;
    logic [CFG_DATA_W-1:0] resume_hold_ticks_reg;
    logic [PERIOD_W-1:0]   pulse_width_ticks_reg;
    logic [PERIOD_W-1:0]   fast_step_delay_reg;
    logic [PERIOD_W-1:0]   slow_step_delay_reg;
    logic [AXES-1:0]       dir_invert_reg;

    // qualifier state
    logic [NUM_SWITCHES-1:0] last_levels_reg;
    logic [TIME_WIDTH-1:0]   since_press_reg [NUM_SWITCHES];
    logic [TIME_WIDTH-1:0]   since_press_next [NUM_SWITCHES];
    logic [TIME_WIDTH-1:0]   since_press_eff [NUM_SWITCHES];
    logic [TIME_WIDTH-1:0]   resume_since_reg;
    logic [TIME_WIDTH-1:0]   resume_since_next;
    logic                    last_resume_level_reg;

    // homing sequencer state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [AXES-1:0]     homed_axes_reg, homed_axes_next;
    logic [AXES-1:0]     pulse_axes_left_reg, pulse_axes_left_next;
    logic [PERIOD_W-1:0] period_count_reg, period_count_next;

    // output register
    logic                    m_valid_reg;
    logic [NUM_SWITCHES-1:0] m_switches_pressed_reg;
    logic                    m_resume_ok_reg;
    logic [AXES-1:0]         m_step_pulses_reg;
    logic [AXES-1:0]         m_dir_levels_reg;
    logic [PHASE_W-1:0]      m_homing_phase_reg;
    logic                    m_homing_done_reg;

    // combinational results for the item being accepted
    logic                    is_tick;
    logic                    accept;
    logic                    levels_changed;
    logic [NUM_SWITCHES-1:0] levels_eff;
    logic                    resume_level_eff;
    logic [TIME_WIDTH-1:0]   resume_since_eff;
    logic [NUM_SWITCHES-1:0] pressed;
    logic                    resume_ok;
    logic [AXES-1:0]         min_pressed;
    logic                    towards_cur;
    logic                    towards_next;
    logic [AXES-1:0]         qualify;
    logic [PERIOD_W-1:0]     delay_lim;
    logic [AXES-1:0]         cur_axis;
    logic [PERIOD_W-1:0]     pulse_count;
    logic [AXES-1:0]         step_pulses;
    logic                    homing_done;

    // the output register frees the input side whenever it is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_tick = (s_opcode == OP_TICK);

    // ---------------------------------------------------------------------------------
    // switch debounce: every timer counts up and saturates; a level change anywhere
    // restarts the timers of all switches that now read low
    // ---------------------------------------------------------------------------------
    assign levels_changed = (s_switch_levels != last_levels_reg);

    always_comb begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (levels_changed && !s_switch_levels[i]) begin
                since_press_next[i] = '0;
            end else if (since_press_reg[i] == TIME_MAX) begin
                since_press_next[i] = TIME_MAX;
            end else begin
                since_press_next[i] = since_press_reg[i] + TIME_WIDTH'(1);
            end
        end
    end

    // a start command leaves the qualifier alone, so its flags come from stored state
    assign levels_eff = is_tick ? s_switch_levels : last_levels_reg;

    always_comb begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            since_press_eff[i] = is_tick ? since_press_next[i] : since_press_reg[i];
            pressed[i] = !levels_eff[i]
                || (CFG_DATA_W'(since_press_eff[i]) < debounce_ticks_reg);
        end
    end

    // min switches drive homing; a missing min switch never reads as pressed
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            min_pressed[a] = (a < NUM_SWITCHES) ? pressed[a % NUM_SWITCHES] : 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------
    // resume button: timer restarts on a press edge, accepted once held long enough
    // ---------------------------------------------------------------------------------
    always_comb begin
        if (!s_resume_level && last_resume_level_reg) begin
            resume_since_next = '0;
        end else if (resume_since_reg == TIME_MAX) begin
            resume_since_next = TIME_MAX;
        end else begin
            resume_since_next = resume_since_reg + TIME_WIDTH'(1);
        end
    end

    assign resume_level_eff = is_tick ? s_resume_level : last_resume_level_reg;
    assign resume_since_eff = is_tick ? resume_since_next : resume_since_reg;
    assign resume_ok = !resume_level_eff
        && (CFG_DATA_W'(resume_since_eff) > resume_hold_ticks_reg);

    // ---------------------------------------------------------------------------------
    // homing sequencer
    // ---------------------------------------------------------------------------------
    assign towards_cur = (phase_reg == PHASE_TOWARDS_FAST) || (phase_reg == PHASE_SLOW);
    assign delay_lim   = (phase_reg == PHASE_SLOW) ? slow_step_delay_reg : fast_step_delay_reg;
    // away phases keep moving axes still on their switch, towards phases those still off
    assign qualify = towards_cur ? (~min_pressed & homed_axes_reg)
                                 : (min_pressed & homed_axes_reg);

    always_comb begin
        phase_next           = phase_reg;
        homed_axes_next      = homed_axes_reg;
        pulse_axes_left_next = pulse_axes_left_reg;
        period_count_next    = period_count_reg;
        step_pulses          = '0;
        homing_done          = 1'b0;
        cur_axis             = '0;
        pulse_count          = '0;
        if (is_tick) begin
            if (phase_reg != PHASE_IDLE) begin
                // no pulse pending: wait out the step delay, then sample the endstops
                if (pulse_axes_left_reg == '0) begin
                    if (period_count_reg < delay_lim) begin
                        period_count_next = period_count_reg + PERIOD_W'(1);
                    end else if (qualify == '0) begin
                        if (phase_reg == PHASE_SLOW) begin
                            phase_next  = PHASE_IDLE;
                            homing_done = 1'b1;
                        end else begin
                            phase_next = phase_reg + PHASE_W'(1);
                        end
                        period_count_next = SAMPLE_NOW;
                    end else begin
                        pulse_axes_left_next = qualify;
                        period_count_next    = '0;
                    end
                end
                // pulse the lowest pending axis; a sampling tick carries the first pulse
                if (phase_next != PHASE_IDLE && pulse_axes_left_next != '0) begin
                    cur_axis    = pulse_axes_left_next & (~pulse_axes_left_next + AXES'(1));
                    step_pulses = cur_axis;
                    pulse_count = period_count_next + PERIOD_W'(1);
                    if (pulse_count >= pulse_width_ticks_reg) begin
                        pulse_axes_left_next = pulse_axes_left_next & ~cur_axis;
                        period_count_next    = '0;
                    end else begin
                        period_count_next = pulse_count;
                    end
                end
            end
        end else if (phase_reg == PHASE_IDLE) begin
            // start command, ignored while a sequence runs
            homed_axes_next      = s_axis_mask;
            phase_next           = PHASE_AWAY_FIRST;
            pulse_axes_left_next = '0;
            period_count_next    = SAMPLE_NOW;
        end
    end

    assign towards_next = (phase_next == PHASE_TOWARDS_FAST) || (phase_next == PHASE_SLOW);

    // ---------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg    <= DEBOUNCE_RST;
            resume_hold_ticks_reg <= RESUME_HOLD_RST;
            pulse_width_ticks_reg <= PULSE_WIDTH_RST;
            fast_step_delay_reg   <= FAST_DELAY_RST;
            slow_step_delay_reg   <= SLOW_DELAY_RST;
            dir_invert_reg        <= DIR_INVERT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:    debounce_ticks_reg    <= cfg_wr_data;
                CFG_RESUME_HOLD: resume_hold_ticks_reg <= cfg_wr_data;
                CFG_PULSE_WIDTH: pulse_width_ticks_reg <= cfg_wr_data[PERIOD_W-1:0];
                CFG_FAST_DELAY:  fast_step_delay_reg   <= cfg_wr_data[PERIOD_W-1:0];
                CFG_SLOW_DELAY:  slow_step_delay_reg   <= cfg_wr_data[PERIOD_W-1:0];
                CFG_DIR_INVERT:  dir_invert_reg        <= cfg_wr_data[AXES-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // block state, updated once per accepted item
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_levels_reg       <= '1;
            resume_since_reg      <= '0;
            last_resume_level_reg <= 1'b1;
            phase_reg             <= PHASE_IDLE;
            homed_axes_reg        <= '0;
            pulse_axes_left_reg   <= '0;
            period_count_reg      <= '0;
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                since_press_reg[i] <= TIME_MAX;
            end
        end else if (accept) begin
            if (is_tick) begin
                last_levels_reg       <= s_switch_levels;
                resume_since_reg      <= resume_since_next;
                last_resume_level_reg <= s_resume_level;
                for (int i = 0; i < NUM_SWITCHES; i++) begin
                    since_press_reg[i] <= since_press_next[i];
                end
            end
            phase_reg           <= phase_next;
            homed_axes_reg      <= homed_axes_next;
            pulse_axes_left_reg <= pulse_axes_left_next;
            period_count_reg    <= period_count_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_switches_pressed_reg <= pressed;
            m_resume_ok_reg        <= resume_ok;
            m_step_pulses_reg      <= step_pulses;
            m_dir_levels_reg       <= {AXES{towards_next}} ^ dir_invert_reg;
            m_homing_phase_reg     <= phase_next;
            m_homing_done_reg      <= homing_done;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_switches_pressed = m_switches_pressed_reg;
    assign m_resume_ok        = m_resume_ok_reg;
    assign m_step_pulses      = m_step_pulses_reg;
    assign m_dir_levels       = m_dir_levels_reg;
    assign m_homing_busy      = (m_homing_phase_reg != PHASE_IDLE);
    assign m_homing_phase     = m_homing_phase_reg;
    assign m_homing_done      = m_homing_done_reg;

    // ---------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------
    // only one axis is pulsed at a time
    `EQHS_ASSERT_SAME(a_single_pulse, aclk, aresetn, m_valid_reg, $onehot0(m_step_pulses_reg))
    // a finishing sequence reports idle in the same result
    `EQHS_ASSERT_SAME(a_done_idle, aclk, aresetn, m_valid_reg && m_homing_done_reg,
        m_homing_phase_reg == PHASE_IDLE && m_step_pulses_reg == '0)
    // pending pulses and emitted pulses stay within the axes being homed
    `EQHS_ASSERT_SAME(a_pending_in_mask, aclk, aresetn, 1'b1,
        (pulse_axes_left_reg & ~homed_axes_reg) == '0)
    `EQHS_ASSERT_SAME(a_pulse_in_mask, aclk, aresetn, m_valid_reg,
        (m_step_pulses_reg & ~homed_axes_reg) == '0)
    // a start command while idle enters the first away phase with a forced sample
    `EQHS_ASSERT_NEXT(a_start_enters, aclk, aresetn,
        accept && s_opcode == OP_START && phase_reg == PHASE_IDLE,
        phase_reg == PHASE_AWAY_FIRST && period_count_reg == SAMPLE_NOW)

endmodule
